@@ src/swcg_pkg.sv @@
package swcg_pkg;

  // Field and register widths
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int WEIGHT_W  = 16;
  localparam int FRAC_BITS = 15;
  localparam int MAX_SIZE  = 1024;
  localparam int TDATA_IN_W = 24;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [SIZE_W-1:0] MAX_SIZE_V = SIZE_W'(MAX_SIZE);

  // Q30 constants
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] HAM_A   = 32'd82377473;
  localparam logic [31:0] HAM_B   = 32'd991364351;

  // Rounding of the Q60 product down to FRAC_BITS
  localparam int ROUND_SHIFT = 60 - FRAC_BITS;

  // Pipeline shape of one axis unit
  localparam int DIV_BITS     = 32;
  localparam int DIV_PER_STG  = 2;
  localparam int DIV_STAGES   = DIV_BITS / DIV_PER_STG;
  localparam int HORNER_STEPS = 6;
  localparam int AXIS_LAT     = DIV_STAGES + 3 * HORNER_STEPS + 5;

  // Request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Horner divisors 2k(2k+1) for k = 6 down to 1, and floor(2^32 / divisor)
  localparam logic [7:0] HORNER_DIV [HORNER_STEPS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'd27531841, 32'd39045157, 32'd59652323,
    32'd102261126, 32'd214748364, 32'd715827882
  };

  typedef enum logic [1:0] {
    MODE_RECT    = 2'd0,
    MODE_HAMMING = 2'd1,
    MODE_HANN    = 2'd2,
    MODE_SINE    = 2'd3
  } mode_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic [IDX_W-1:0] row_m;
    logic [IDX_W-1:0] row_last;
    logic [IDX_W-1:0] col_m;
    logic [IDX_W-1:0] col_last;
    logic             oor;
    logic             row_unity;
    logic             col_unity;
  } req_t;

endpackage

@@ src/swcg_front.sv @@
module swcg_front (
  input  logic [swcg_pkg::IDX_W-1:0]  row_index,
  input  logic [swcg_pkg::IDX_W-1:0]  col_index,
  input  logic [swcg_pkg::SIZE_W-1:0] window_width,
  input  logic [swcg_pkg::SIZE_W-1:0] window_height,
  input  swcg_pkg::mode_t             window_mode,
  output swcg_pkg::req_t              req
);
  import swcg_pkg::*;

  logic [SIZE_W-1:0] w_n;
  logic [SIZE_W-1:0] h_n;
  logic [IDX_W-1:0]  w_last;
  logic [IDX_W-1:0]  h_last;
  logic [IDX_W-1:0]  col_mirror;
  logic [IDX_W-1:0]  row_mirror;

  assign w_n = (window_width  > MAX_SIZE_V) ? MAX_SIZE_V : window_width;
  assign h_n = (window_height > MAX_SIZE_V) ? MAX_SIZE_V : window_height;

  // A size of zero wraps here, but then every index is out of range anyway.
  assign w_last = IDX_W'(w_n - SIZE_W'(1));
  assign h_last = IDX_W'(h_n - SIZE_W'(1));

  assign col_mirror = w_last - col_index;
  assign row_mirror = h_last - row_index;

  always_comb begin
    req.oor       = ({1'b0, row_index} >= h_n) || ({1'b0, col_index} >= w_n);
    req.row_last  = h_last;
    req.col_last  = w_last;
    // Fold about the center so the phase stays within a quarter turn.
    req.row_m     = (row_index <= row_mirror) ? row_index : row_mirror;
    req.col_m     = (col_index <= col_mirror) ? col_index : col_mirror;
    req.row_unity = (h_n <= SIZE_W'(1)) || (window_mode == MODE_RECT);
    req.col_unity = (w_n <= SIZE_W'(1)) || (window_mode == MODE_RECT);
  end

endmodule

@@ src/swcg_queue.sv @@
module swcg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swcg_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output swcg_pkg::req_t head,
  output logic           nonempty
);
  import swcg_pkg::*;

  req_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/swcg_axis.sv @@
module swcg_axis (
  input  logic                       clk,
  input  logic                       en,
  input  logic [swcg_pkg::IDX_W-1:0] m,
  input  logic [swcg_pkg::IDX_W-1:0] last,
  input  swcg_pkg::mode_t            mode,
  output logic [31:0]                weight
);
  import swcg_pkg::*;

  // Phase divider: f = floor(m * 2^32 / last), two quotient bits per stage.
  logic [IDX_W-1:0] d_rem  [DIV_STAGES+1];
  logic [31:0]      d_q    [DIV_STAGES+1];
  logic [IDX_W-1:0] d_last [DIV_STAGES+1];

  assign d_rem[0]  = m;
  assign d_q[0]    = '0;
  assign d_last[0] = last;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [IDX_W-1:0] rem_n;
    logic [31:0]      q_n;
    logic [IDX_W:0]   r2;

    always_comb begin
      rem_n = d_rem[g];
      q_n   = d_q[g];
      r2    = '0;
      for (int b = 0; b < DIV_PER_STG; b++) begin
        r2 = {rem_n, 1'b0};
        if (r2 >= {1'b0, d_last[g]}) begin
          r2  = r2 - {1'b0, d_last[g]};
          q_n = {q_n[30:0], 1'b1};
        end else begin
          q_n = {q_n[30:0], 1'b0};
        end
        rem_n = r2[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[g+1]  <= rem_n;
        d_q[g+1]    <= q_n;
        d_last[g+1] <= d_last[g];
      end
    end
  end

  // Angle and its square, Q30
  logic [30:0] x_r;
  logic [30:0] x_b;
  logic [31:0] x2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= 31'((64'(d_q[DIV_STAGES]) * 64'(PI_Q30)) >> 32);
      x_b  <= x_r;
      x2_r <= 32'((62'(x_r) * 62'(x_r)) >> 30);
    end
  end

  // Horner evaluation of the sine series, three stages per term.
  logic [30:0] h_t  [HORNER_STEPS+1];
  logic [30:0] h_x  [HORNER_STEPS+1];
  logic [31:0] h_x2 [HORNER_STEPS+1];

  assign h_t[0]  = Q30_ONE;
  assign h_x[0]  = x_b;
  assign h_x2[0] = x2_r;

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic [31:0] a_r;
    logic [31:0] a_b;
    logic [31:0] q0_r;
    logic [30:0] xa;
    logic [30:0] xb;
    logic [31:0] x2a;
    logic [31:0] x2b;
    logic [39:0] rem;
    logic [31:0] quo;

    // One compare and subtract finishes the reciprocal estimate.
    always_comb begin
      rem = 40'(a_b) - 40'(q0_r) * 40'(HORNER_DIV[j]);
      quo = (rem >= 40'(HORNER_DIV[j])) ? q0_r + 32'd1 : q0_r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r         <= 32'((63'(h_x2[j]) * 63'(h_t[j])) >> 30);
        xa          <= h_x[j];
        x2a         <= h_x2[j];
        q0_r        <= 32'((64'(a_r) * 64'(HORNER_RECIP[j])) >> 32);
        a_b         <= a_r;
        xb          <= xa;
        x2b         <= x2a;
        h_t[j+1]    <= Q30_ONE - 31'(quo);
        h_x[j+1]    <= xb;
        h_x2[j+1]   <= x2b;
      end
    end
  end

  logic [30:0] s_r;
  logic [30:0] s_b;
  logic [31:0] s2_r;
  logic [31:0] ham;

  assign ham = HAM_A + 32'((64'(HAM_B) * 64'(s2_r)) >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= 31'((62'(h_x[HORNER_STEPS]) * 62'(h_t[HORNER_STEPS])) >> 30);
      s_b  <= s_r;
      s2_r <= 32'((62'(s_r) * 62'(s_r)) >> 30);
      unique case (mode)
        MODE_SINE:    weight <= 32'(s_b);
        MODE_HANN:    weight <= s2_r;
        MODE_HAMMING: weight <= ham;
        MODE_RECT:    weight <= 32'(Q30_ONE);
      endcase
    end
  end

endmodule

@@ src/swcg_back.sv @@
module swcg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  swcg_pkg::mode_t               mode,
  input  swcg_pkg::req_t                req,
  input  logic                          req_valid,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swcg_pkg::WEIGHT_W-1:0] m_tdata,
  output logic                          m_tuser
);
  import swcg_pkg::*;

  logic        en;
  logic [31:0] row_w;
  logic [31:0] col_w;

  // The whole back end advances together; it holds only when the output
  // register is full and not being taken.
  assign en  = !m_tvalid || m_tready;
  assign pop = en && req_valid;

  swcg_axis u_row (
    .clk    (clk),
    .en     (en),
    .m      (req.row_m),
    .last   (req.row_last),
    .mode   (mode),
    .weight (row_w)
  );

  swcg_axis u_col (
    .clk    (clk),
    .en     (en),
    .m      (req.col_m),
    .last   (req.col_last),
    .mode   (mode),
    .weight (col_w)
  );

  logic sb_valid [AXIS_LAT];
  logic sb_oor   [AXIS_LAT];
  logic sb_ur    [AXIS_LAT];
  logic sb_uc    [AXIS_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_LAT; i++) begin
        sb_valid[i] <= 1'b0;
      end
    end else if (en) begin
      sb_valid[0] <= req_valid;
      for (int i = 1; i < AXIS_LAT; i++) begin
        sb_valid[i] <= sb_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_oor[0] <= req.oor;
      sb_ur[0]  <= req.row_unity;
      sb_uc[0]  <= req.col_unity;
      for (int i = 1; i < AXIS_LAT; i++) begin
        sb_oor[i] <= sb_oor[i-1];
        sb_ur[i]  <= sb_ur[i-1];
        sb_uc[i]  <= sb_uc[i-1];
      end
    end
  end

  logic [31:0] wr;
  logic [31:0] wc;
  logic        p_valid;
  logic        p_oor;
  logic [63:0] prod;
  logic [65:0] rounded;

  assign wr = sb_ur[AXIS_LAT-1] ? 32'(Q30_ONE) : row_w;
  assign wc = sb_uc[AXIS_LAT-1] ? 32'(Q30_ONE) : col_w;
  assign rounded = ({1'b0, prod, 1'b0} + (66'(1) << ROUND_SHIFT)) >> (ROUND_SHIFT + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      p_valid  <= sb_valid[AXIS_LAT-1];
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= 64'(wr) * 64'(wc);
      p_oor   <= sb_oor[AXIS_LAT-1];
      m_tdata <= p_oor ? '0 : rounded[WEIGHT_W-1:0];
      m_tuser <= p_oor;
    end
  end

endmodule

@@ src/separable_window_coefficient_gen_unit.sv @@
// Separable window coefficient generator.
// Each transfer on the slave stream asks for the weight of a two-dimensional
// window at (row_index, col_index); each transfer on the master stream returns
// the weight in unsigned Q1.15 on m_tdata and an out-of-range flag on m_tuser.
// Results come back in request order, one per request.
// Window width, height and mode are set through the APB port; the user must
// do so only while the block is idle, which the block itself does not enforce.
// pready is always high and reads return the register values. Throughput is
// one request per cycle while the receiver keeps taking results. An accepted
// request is written into the queue, then popped from it into the first of the
// 39 register stages of each axis unit (a 16-stage phase divider giving two
// quotient bits per stage, then the pipelined sine series and mode
// selection), then one more for the product of the two axis weights and one
// for rounding into the output register.
// When the receiver stalls, the back end holds in place and the four-entry
// request queue keeps accepting until it fills, then s_tready drops.
// Reset clears the queue, the pipeline valid bits and the registers to
// width 1, height 1 and rectangular mode.
module separable_window_coefficient_gen_unit (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swcg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swcg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swcg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swcg_pkg::TDATA_IN_W-1:0] s_tdata,  // row_index, col_index, zero pad
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swcg_pkg::WEIGHT_W-1:0]   m_tdata,  // weight
  output logic                            m_tuser   // index_out_of_range
);
  import swcg_pkg::*;

  logic [SIZE_W-1:0] window_width;
  logic [SIZE_W-1:0] window_height;
  mode_t             window_mode;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= SIZE_W'(1);
      window_height <= SIZE_W'(1);
      window_mode   <= MODE_RECT;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WIDTH:  window_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: window_height <= pwdata[SIZE_W-1:0];
        REG_MODE:   window_mode   <= mode_t'(pwdata[1:0]);
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DATA_W'(window_width);
      REG_HEIGHT: prdata = APB_DATA_W'(window_height);
      REG_MODE:   prdata = APB_DATA_W'(window_mode);
      default:    prdata = '0;
    endcase
  end

  req_t req_in;
  req_t req_head;
  logic q_full;
  logic q_nonempty;
  logic q_pop;

  assign s_tready = !q_full;

  swcg_front u_front (
    .row_index     (s_tdata[IDX_W-1:0]),
    .col_index     (s_tdata[2*IDX_W-1:IDX_W]),
    .window_width  (window_width),
    .window_height (window_height),
    .window_mode   (window_mode),
    .req           (req_in)
  );

  swcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (req_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (req_head),
    .nonempty  (q_nonempty)
  );

  swcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (window_mode),
    .req       (req_head),
    .req_valid (q_nonempty),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
